// ----- rtl/vpa_pkg.sv -----
// Shared types, constants and the helper function of the voxel point accumulator.
// Depends on nothing; the top level and the testbench import it, vpa_ram does not.
`default_nettype none

package vpa_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int NUM_CELLS = 32768;
  localparam int FRAC_BITS = 16;

  localparam int POS_W    = 32;
  localparam int WEIGHT_W = 16;
  localparam int SEL_W    = 15;
  localparam int SUM_W    = 48;
  localparam int WSUM_W   = 40;
  localparam int CELLS_W  = 6;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int SIDE_W   = CELLS_W + 1;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int IDX_W    = 3 * SIDE_W;
  localparam int ADDR_W   = $clog2(NUM_CELLS);
  localparam int PROD_W   = 2 * POS_W;
  localparam int SCALED_W = PROD_W - 2 * FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z  = 3'd6;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic        [WSUM_W-1:0] w;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OFFSET,
    ST_MUL,
    ST_CMP,
    ST_IDX1,
    ST_IDX2,
    ST_CHK,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Requested cell count rounded up to even and limited to the largest side.
  function automatic logic [SIDE_W-1:0] side_of(input logic [CELLS_W-1:0] c);
    logic [SIDE_W-1:0] s;
    s = SIDE_W'(c) + SIDE_W'(c[0]);
    if (s > SIDE_W'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the cell store of the voxel point accumulator.
`default_nettype none

module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/voxel_point_accumulator.sv -----
// Top level of the voxel point accumulator: configuration, cell mapping and
// the read-modify-write sequencer. Depends on vpa_pkg and vpa_ram.
//
// Usage. An item transfers at a rising edge with start high and busy low.
// req_type selects accumulate (position and weight into the point's cell) or
// read (the sums of cell cell_sel). Each item gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall, so it must take it.
// Configuration is written through cfg_we, cfg_index and cfg_data, one
// register per edge, and should only be written while busy is low and no
// result is pending.
// Sequence: a point in a valid cell passes OFFSET, then MUL and CMP once per
// axis, IDX1, IDX2, CHK, READ and UPDATE; a rejected point or invalid read ends
// after CHK. busy falls in the cycle done is high, so the next item may transfer
// at the edge that ends it; a new item is not taken before the last one is done.
// The sequence is set by the single shared 32x32 multiplier, used once per axis,
// and by the registered read of the cell store.
// Reset: the state, done and configuration registers take their reset values and
// the store is cleared by a pass over all 32768 cells, one cell a cycle, with busy high throughout.
`default_nettype none

module voxel_point_accumulator
  import vpa_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type,
  input  wire logic signed [POS_W-1:0]    pos_x,
  input  wire logic signed [POS_W-1:0]    pos_y,
  input  wire logic signed [POS_W-1:0]    pos_z,
  input  wire logic [WEIGHT_W-1:0]        weight,
  input  wire logic [SEL_W-1:0]           cell_sel,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data,
  output logic                            done,
  output logic                            accepted,
  output logic [SEL_W-1:0]                cell_out,
  output logic signed [SUM_W-1:0]         sum_px,
  output logic signed [SUM_W-1:0]         sum_py,
  output logic signed [SUM_W-1:0]         sum_pz,
  output logic [WSUM_W-1:0]               weight_total
);

  localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'((64'sd1 <<< (SUM_W-1)) - 64'sd1);
  localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W+1)'(64'sd1 <<< (SUM_W-1));

  logic signed [POS_W-1:0] origin [3];
  logic [POS_W-1:0]        inv_cell_size;
  logic [CELLS_W-1:0]      cells [3];
  logic [SIDE_W-1:0]       side [3];

  state_t state, state_next;

  logic                    req_q;
  logic signed [POS_W-1:0] pos_q [3];
  logic [WEIGHT_W-1:0]     weight_q;
  logic [SEL_W-1:0]        sel_q;
  logic                    neg [3];
  logic [POS_W-1:0]        off [3];
  logic [1:0]              ax;
  logic [PROD_W-1:0]       prod;
  logic [COORD_W-1:0]      coord [3];
  logic                    ok;
  logic [IDX_W-1:0]        part;
  logic [IDX_W-1:0]        plane;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        total;
  logic [ADDR_W-1:0]       clr_cnt;

  logic                    hit;
  logic                    clr_last;
  logic                    in_side;
  logic [SCALED_W-1:0]     scaled;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  entry_t                  ram_wdata;
  logic                    ram_re;
  entry_t                  ram_rdata;
  entry_t                  upd;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (r > SUM_HI) begin
      r = SUM_HI;
    end else if (r < SUM_LO) begin
      r = SUM_LO;
    end
    return r[SUM_W-1:0];
  endfunction

  function automatic logic [WSUM_W-1:0] sat_wadd(
    input logic [WSUM_W-1:0]   a,
    input logic [WEIGHT_W-1:0] b
  );
    logic [WSUM_W:0] r;
    r = (WSUM_W+1)'(a) + (WSUM_W+1)'(b);
    if (r[WSUM_W]) begin
      return {WSUM_W{1'b1}};
    end
    return r[WSUM_W-1:0];
  endfunction

  assign side[0] = side_of(cells[0]);
  assign side[1] = side_of(cells[1]);
  assign side[2] = side_of(cells[2]);

  assign busy     = (state != ST_IDLE);
  assign clr_last = (clr_cnt == ADDR_W'(NUM_CELLS - 1));
  assign scaled   = prod[PROD_W-1:2*FRAC_BITS];
  assign in_side  = !neg[ax] && (scaled < SCALED_W'(side[ax]));

  always_comb begin
    if (req_q == REQ_READ) begin
      hit = (idx < total) && (idx < IDX_W'(NUM_CELLS));
    end else begin
      hit = ok && (idx < IDX_W'(NUM_CELLS));
    end
  end

  always_comb begin
    upd.sx = sat_add(ram_rdata.sx, pos_q[0]);
    upd.sy = sat_add(ram_rdata.sy, pos_q[1]);
    upd.sz = sat_add(ram_rdata.sz, pos_q[2]);
    upd.w  = sat_wadd(ram_rdata.w, weight_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]     <= '0;
      origin[1]     <= '0;
      origin[2]     <= '0;
      inv_cell_size <= POS_W'(65536);
      cells[0]      <= CELLS_W'(32);
      cells[1]      <= CELLS_W'(32);
      cells[2]      <= CELLS_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin[0]     <= cfg_data;
        REG_ORIGIN_Y: origin[1]     <= cfg_data;
        REG_ORIGIN_Z: origin[2]     <= cfg_data;
        REG_INV_CELL: inv_cell_size <= cfg_data;
        REG_CELLS_X:  cells[0]      <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Y:  cells[1]      <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Z:  cells[2]      <= cfg_data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_OFFSET;
      ST_OFFSET: state_next = ST_MUL;
      ST_MUL:    state_next = ST_CMP;
      ST_CMP:    state_next = (ax == 2'd2) ? ST_IDX1 : ST_MUL;
      ST_IDX1:   state_next = ST_IDX2;
      ST_IDX2:   state_next = ST_CHK;
      ST_CHK:    state_next = hit ? ST_READ : ST_IDLE;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = upd;
    ram_re    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_UPDATE: begin
        ram_we = (req_q == REQ_ACCUM);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE) || (state == ST_CHK && !hit);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q    <= req_type;
        pos_q[0] <= pos_x;
        pos_q[1] <= pos_y;
        pos_q[2] <= pos_z;
        weight_q <= weight;
        sel_q    <= cell_sel;
      end
      ST_OFFSET: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [POS_W:0] diff;
          diff   = (POS_W+1)'(pos_q[a]) - (POS_W+1)'(origin[a]);
          neg[a] <= diff[POS_W];
          off[a] <= diff[POS_W-1:0];
        end
        ax <= 2'd0;
        ok <= 1'b1;
      end
      ST_MUL: begin
        prod <= PROD_W'(off[ax]) * PROD_W'(inv_cell_size);
      end
      ST_CMP: begin
        ok        <= ok && in_side;
        coord[ax] <= scaled[COORD_W-1:0];
        ax        <= ax + 2'd1;
      end
      ST_IDX1: begin
        part  <= IDX_W'(coord[2]) * IDX_W'(side[1]) + IDX_W'(coord[1]);
        plane <= IDX_W'(side[2]) * IDX_W'(side[1]);
      end
      ST_IDX2: begin
        total <= plane * IDX_W'(side[0]);
        if (req_q == REQ_READ) begin
          idx <= IDX_W'(sel_q);
        end else begin
          idx <= part * IDX_W'(side[0]) + IDX_W'(coord[0]);
        end
      end
      ST_CHK: begin
        if (!hit) begin
          accepted     <= 1'b0;
          cell_out     <= (req_q == REQ_READ) ? sel_q : '0;
          sum_px       <= '0;
          sum_py       <= '0;
          sum_pz       <= '0;
          weight_total <= '0;
        end
      end
      ST_UPDATE: begin
        accepted <= 1'b1;
        cell_out <= idx[SEL_W-1:0];
        if (req_q == REQ_ACCUM) begin
          sum_px       <= upd.sx;
          sum_py       <= upd.sy;
          sum_pz       <= upd.sz;
          weight_total <= upd.w;
        end else begin
          sum_px       <= ram_rdata.sx;
          sum_py       <= ram_rdata.sy;
          sum_pz       <= ram_rdata.sz;
          weight_total <= ram_rdata.w;
        end
      end
      default: ;
    endcase
  end

  vpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- bench/voxel_point_accumulator_test.sv -----
// Self-checking testbench of voxel_point_accumulator: directed and random point
// binning and cell reads, checked against a cell-store predictor kept here.
// Depends on vpa_pkg and the voxel_point_accumulator RTL.
`default_nettype none

module voxel_point_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vpa_pkg::*;

  typedef struct {
    bit              accepted;
    bit [SEL_W-1:0]  cell_idx;
    bit [SUM_W-1:0]  sx;
    bit [SUM_W-1:0]  sy;
    bit [SUM_W-1:0]  sz;
    bit [WSUM_W-1:0] w;
  } voxel_result_t;

  typedef enum {AXIS_INSIDE, AXIS_BELOW, AXIS_ABOVE} axis_pick_t;

  localparam longint POS_SUM_HIGH = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint POS_SUM_LOW  = -(64'sd1 <<< (SUM_W - 1));
  localparam longint WEIGHT_HIGH  = (64'sd1 <<< WSUM_W) - 1;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     req_type;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [WEIGHT_W-1:0]      weight;
  logic [SEL_W-1:0]         cell_sel;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     done;
  logic                     accepted;
  logic [SEL_W-1:0]         cell_out;
  logic signed [SUM_W-1:0]  sum_px;
  logic signed [SUM_W-1:0]  sum_py;
  logic signed [SUM_W-1:0]  sum_pz;
  logic [WSUM_W-1:0]        weight_total;

  voxel_point_accumulator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .weight       (weight),
    .cell_sel     (cell_sel),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .accepted     (accepted),
    .cell_out     (cell_out),
    .sum_px       (sum_px),
    .sum_py       (sum_py),
    .sum_pz       (sum_pz),
    .weight_total (weight_total)
  );

  longint voxel_sum_x [NUM_CELLS];
  longint voxel_sum_y [NUM_CELLS];
  longint voxel_sum_z [NUM_CELLS];
  longint voxel_weight [NUM_CELLS];

  bit signed [31:0] grid_origin_x;
  bit signed [31:0] grid_origin_y;
  bit signed [31:0] grid_origin_z;
  bit [31:0]        grid_inv;
  bit [5:0]         grid_cells_x;
  bit [5:0]         grid_cells_y;
  bit [5:0]         grid_cells_z;

  voxel_result_t pending_cells[$];
  int            mismatch_count;
  int            last_cell;
  bit            back_to_back;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < 50) begin
      $display("cell check failed at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic bit [6:0] grid_side(bit [5:0] n);
    bit [6:0] s;
    s = 7'(n) + 7'(n[0]);
    if (s > 7'(MAX_SIDE)) begin
      s = 7'(MAX_SIDE);
    end
    return s;
  endfunction

  function automatic bit axis_cell(input bit signed [31:0] p, input bit signed [31:0] o,
                                   input bit [6:0] side, output bit [5:0] c);
    longint    off;
    bit [63:0] prod;
    c = '0;
    off = longint'(p) - longint'(o);
    if (off < 0) begin
      return 1'b0;
    end
    prod = 64'(off) * 64'(grid_inv);
    if ((prod >> 32) >= 64'(side)) begin
      return 1'b0;
    end
    c = prod[37:32];
    return 1'b1;
  endfunction

  function automatic longint clamp_position(longint a);
    if (a > POS_SUM_HIGH) begin
      return POS_SUM_HIGH;
    end
    if (a < POS_SUM_LOW) begin
      return POS_SUM_LOW;
    end
    return a;
  endfunction

  task automatic bin_request(bit rtype, bit signed [31:0] px, bit signed [31:0] py,
                             bit signed [31:0] pz, bit [15:0] w, bit [14:0] sel);
    voxel_result_t r;
    bit [6:0]      dx;
    bit [6:0]      dy;
    bit [6:0]      dz;
    bit [5:0]      ci;
    bit [5:0]      cj;
    bit [5:0]      ck;
    bit            in_x;
    bit            in_y;
    bit            in_z;
    int            total;
    int            idx;
    r = '{default: 0};
    idx = -1;
    dx = grid_side(grid_cells_x);
    dy = grid_side(grid_cells_y);
    dz = grid_side(grid_cells_z);
    total = int'(dx) * int'(dy) * int'(dz);
    if (rtype == REQ_READ) begin
      r.cell_idx = sel;
      if (int'(sel) < total && int'(sel) < NUM_CELLS) begin
        idx = int'(sel);
      end
    end else begin
      in_x = axis_cell(px, grid_origin_x, dx, ci);
      in_y = axis_cell(py, grid_origin_y, dy, cj);
      in_z = axis_cell(pz, grid_origin_z, dz, ck);
      if (in_x && in_y && in_z) begin
        idx = (int'(ck) * int'(dy) + int'(cj)) * int'(dx) + int'(ci);
        if (idx < NUM_CELLS) begin
          voxel_sum_x[idx] = clamp_position(voxel_sum_x[idx] + longint'(px));
          voxel_sum_y[idx] = clamp_position(voxel_sum_y[idx] + longint'(py));
          voxel_sum_z[idx] = clamp_position(voxel_sum_z[idx] + longint'(pz));
          voxel_weight[idx] = voxel_weight[idx] + longint'(w);
          if (voxel_weight[idx] > WEIGHT_HIGH) begin
            voxel_weight[idx] = WEIGHT_HIGH;
          end
          r.cell_idx = SEL_W'(idx);
          last_cell = idx;
        end else begin
          idx = -1;
        end
      end
    end
    if (idx >= 0) begin
      r.accepted = 1'b1;
      r.sx = SUM_W'(voxel_sum_x[idx]);
      r.sy = SUM_W'(voxel_sum_y[idx]);
      r.sz = SUM_W'(voxel_sum_z[idx]);
      r.w  = WSUM_W'(voxel_weight[idx]);
    end
    pending_cells = {pending_cells, r};
  endtask

  function automatic int next_gap();
    int r;
    if (back_to_back) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(bit rtype, bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                              bit [15:0] w, bit [14:0] sel);
    int gap;
    req_type <= rtype;
    pos_x    <= px;
    pos_y    <= py;
    pos_z    <= pz;
    weight   <= w;
    cell_sel <= sel;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    bin_request(rtype, px, py, pz, w, sel);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, bit [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_ORIGIN_X: grid_origin_x = value;
      REG_ORIGIN_Y: grid_origin_y = value;
      REG_ORIGIN_Z: grid_origin_z = value;
      REG_INV_CELL: grid_inv = value;
      REG_CELLS_X:  grid_cells_x = value[5:0];
      REG_CELLS_Y:  grid_cells_y = value[5:0];
      REG_CELLS_Z:  grid_cells_z = value[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_grid(bit [31:0] ox, bit [31:0] oy, bit [31:0] oz, bit [31:0] inv,
                              bit [5:0] cx, bit [5:0] cy, bit [5:0] cz);
    wait_idle();
    write_register(REG_ORIGIN_X, ox);
    write_register(REG_ORIGIN_Y, oy);
    write_register(REG_ORIGIN_Z, oz);
    write_register(REG_INV_CELL, inv);
    write_register(REG_CELLS_X, 32'(cx));
    write_register(REG_CELLS_Y, 32'(cy));
    write_register(REG_CELLS_Z, 32'(cz));
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] axis_position(bit [31:0] org, int c, bit [6:0] side,
                                              axis_pick_t pick);
    bit [63:0] off;
    if (pick == AXIS_BELOW || (pick == AXIS_ABOVE && grid_inv == 0)) begin
      return org - 32'd1;
    end
    if (pick == AXIS_ABOVE) begin
      off = ((64'(side) << 32) / 64'(grid_inv)) + 64'd1;
    end else if (grid_inv == 0) begin
      off = 64'($urandom_range(0, 4095));
    end else begin
      off = ((64'(c) << 32) | 64'($urandom)) / 64'(grid_inv);
    end
    if (off > 64'hFFFF_FFFF) begin
      off = 64'hFFFF_FFFF;
    end
    return org + off[31:0];
  endfunction

  function automatic bit [5:0] random_cells();
    if ($urandom_range(0, 9) == 0) begin
      return 6'($urandom);
    end
    return 6'($urandom_range(1, 32));
  endfunction

  always @(posedge clk) begin : check_results
    voxel_result_t want;
    if (!rst && done) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("result for cell %0d with nothing expected", cell_out));
      end else begin
        want = pending_cells.pop_front();
        if (accepted !== want.accepted) begin
          report_mismatch($sformatf("accepted %b, want %b", accepted, want.accepted));
        end
        if (cell_out !== want.cell_idx) begin
          report_mismatch($sformatf("cell_out %0d, want %0d", cell_out, want.cell_idx));
        end
        if (sum_px !== want.sx) begin
          report_mismatch($sformatf("cell %0d sum_px %h, want %h", want.cell_idx, sum_px,
                                    want.sx));
        end
        if (sum_py !== want.sy) begin
          report_mismatch($sformatf("cell %0d sum_py %h, want %h", want.cell_idx, sum_py,
                                    want.sy));
        end
        if (sum_pz !== want.sz) begin
          report_mismatch($sformatf("cell %0d sum_pz %h, want %h", want.cell_idx, sum_pz,
                                    want.sz));
        end
        if (weight_total !== want.w) begin
          report_mismatch($sformatf("cell %0d weight_total %h, want %h", want.cell_idx,
                                    weight_total, want.w));
        end
      end
    end
  end

  task automatic test_default_grid();
    send_request(REQ_ACCUM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, '0);
    send_request(REQ_ACCUM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, '0);
    send_request(REQ_ACCUM, 32'h001F_FFFF, 32'h0010_0000, 32'h001F_0000, 16'h1234, '0);
    send_request(REQ_ACCUM, 32'h0020_0000, 32'h0001_0000, 32'h0001_0000, 16'h0101, '0);
    send_request(REQ_ACCUM, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000, 16'h0101, '0);
    send_request(REQ_ACCUM, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 16'h0101, '0);
    send_request(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 15'd0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'h7FFF);
    send_request(REQ_READ, '0, '0, '0, '0, 15'((31 * 32 + 16) * 32 + 31));
  endtask

  task automatic test_grid_edges();
    program_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'd1, 6'd63, 6'd63, 6'd32);
    send_request(REQ_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, '0);
    send_request(REQ_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h8000, '0);
    send_request(REQ_ACCUM, 32'h0000_0000, 32'h7FFF_FFFE, 32'h0000_0000, 16'h0001, '0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd0);
    program_grid(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 6'd1, 6'd1, 6'd1);
    send_request(REQ_ACCUM, 32'd0, 32'd2, 32'd0, 16'h00FF, '0);
    send_request(REQ_ACCUM, 32'd1, 32'd2, 32'd0, 16'h00FF, '0);
    send_request(REQ_ACCUM, 32'd2, 32'd2, 32'd0, 16'h00FF, '0);
    send_request(REQ_ACCUM, 32'd3, 32'd2, 32'd0, 16'h00FF, '0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd7);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd8);
  endtask

  task automatic test_zero_scale();
    program_grid(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 6'd3, 6'd5, 6'd32);
    send_request(REQ_ACCUM, 32'h7FFF_FFFF, 32'h0001_0000, 32'h4000_0000, 16'h7FFF, '0);
    send_request(REQ_ACCUM, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0000, 16'h7FFF, '0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd767);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd768);
  endtask

  task automatic test_zero_side();
    program_grid(32'h0, 32'h0, 32'h0, 32'd65536, 6'd0, 6'd32, 6'd32);
    send_request(REQ_ACCUM, 32'h0, 32'h0, 32'h0, 16'h0100, '0);
    send_request(REQ_READ, '0, '0, '0, '0, 15'd0);
  endtask

  task automatic test_random_binning(int n_items);
    int         sent;
    int         len;
    int         pick;
    int         b;
    bit         hot;
    bit [31:0]  org [3];
    bit [31:0]  inv;
    bit [6:0]   dx;
    bit [6:0]   dy;
    bit [6:0]   dz;
    int         total;
    bit [15:0]  w;
    bit [14:0]  sel;
    axis_pick_t mx;
    axis_pick_t my;
    axis_pick_t mz;
    axis_pick_t bad;
    sent = 0;
    while (sent < n_items) begin
      foreach (org[a]) begin
        org[a] = ($urandom_range(0, 7) == 0) ? $urandom : 32'(int'($urandom) >>> 2);
      end
      b = $urandom_range(12, 31);
      inv = $urandom >> (31 - b);
      inv[b] = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        inv = $urandom;
      end
      program_grid(org[0], org[1], org[2], inv, random_cells(), random_cells(),
                   random_cells());
      back_to_back = ($urandom_range(0, 3) == 0);
      hot = ($urandom_range(0, 3) == 0);
      dx = grid_side(grid_cells_x);
      dy = grid_side(grid_cells_y);
      dz = grid_side(grid_cells_z);
      total = int'(dx) * int'(dy) * int'(dz);
      len = $urandom_range(90, 170);
      if (len > n_items - sent) begin
        len = n_items - sent;
      end
      repeat (len) begin
        pick = $urandom_range(0, 99);
        w = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        if (pick < 70 && total > 0) begin
          mx = AXIS_INSIDE;
          my = AXIS_INSIDE;
          mz = AXIS_INSIDE;
          if (pick >= 58) begin
            bad = $urandom_range(0, 1) ? AXIS_BELOW : AXIS_ABOVE;
            case ($urandom_range(0, 2))
              0: mx = bad;
              1: my = bad;
              default: mz = bad;
            endcase
          end
          send_request(REQ_ACCUM,
            axis_position(grid_origin_x,
                          hot ? $urandom_range(0, dx > 1) : $urandom_range(0, dx - 1), dx, mx),
            axis_position(grid_origin_y,
                          hot ? $urandom_range(0, dy > 1) : $urandom_range(0, dy - 1), dy, my),
            axis_position(grid_origin_z,
                          hot ? $urandom_range(0, dz > 1) : $urandom_range(0, dz - 1), dz, mz),
            w, 15'($urandom));
        end else if (pick < 90) begin
          case ($urandom_range(0, 4))
            0: sel = 15'($urandom);
            1, 2: sel = (total > 0) ? 15'(last_cell % total) : 15'($urandom);
            default: sel = (total > 0) ? 15'($urandom_range(0, total - 1)) : 15'($urandom);
          endcase
          send_request(REQ_READ, $urandom, $urandom, $urandom, w, sel);
        end else begin
          send_request(1'($urandom), $urandom, $urandom, $urandom, w, 15'($urandom));
        end
        sent++;
      end
      back_to_back = 1'b0;
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req_type  <= REQ_ACCUM;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    weight    <= '0;
    cell_sel  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= '0;
    grid_origin_x = '0;
    grid_origin_y = '0;
    grid_origin_z = '0;
    grid_inv      = 32'd65536;
    grid_cells_x  = 6'd32;
    grid_cells_y  = 6'd32;
    grid_cells_z  = 6'd32;
    mismatch_count = 0;
    last_cell      = 0;
    back_to_back   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);
    test_default_grid();
    test_grid_edges();
    test_zero_scale();
    test_zero_side();
    test_random_binning(1125);
    start <= 1'b0;
    for (int n = 0; n < 200 && pending_cells.size() != 0; n++) @(posedge clk);
    if (pending_cells.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_cells.size()));
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/vpa_pkg.sv
rtl/vpa_ram.sv
rtl/voxel_point_accumulator.sv
bench/voxel_point_accumulator_test.sv
